/* rtl/core/i2c_master_byte_engine_core_macros.svh */
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cm assertion failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cm assertion failed");

`endif

/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_SEND  = 3'd3,
		CMD_RECV  = 3'd4
	} cmd_t;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd5;

	// send sequence: 8 bits x (sda, scl up, scl down), then ack slot
	localparam logic [5:0] SEND_BIT_END = 6'd24;
	localparam logic [5:0] SEND_ACK_SDA = 6'd24;
	localparam logic [5:0] SEND_ACK_UP  = 6'd25;
	localparam logic [5:0] SEND_ACK_DN  = 6'd26;

	// receive sequence: 8 bits x (scl up, scl down), then ack slot
	localparam logic [5:0] RECV_BIT_END = 6'd16;
	localparam logic [5:0] RECV_ACK_SDA = 6'd16;
	localparam logic [5:0] RECV_ACK_UP  = 6'd17;
	localparam logic [5:0] RECV_ACK_DN  = 6'd18;
	localparam logic [5:0] RECV_REL_SDA = 6'd19;

	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  phase;
		logic [15:0] wait_cnt;
		logic        stretch;
		logic [7:0]  shift;
		logic        sda_drv;
		logic        scl_drv;
		logic        ack;
		logic        ack_give;
		logic [7:0]  rx_hold;
	} eng_st_t;

	typedef struct packed {
		logic       sda_pull_low;
		logic       scl_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} eng_res_t;

	// remainder mod 3 of a 5-bit value, one bit per step
	function automatic logic [1:0] mod3(input logic [4:0] v);
		logic [2:0] t;
		logic [1:0] r;
		r = 2'd0;
		for (int i = 4; i >= 0; i--) begin
			t = {r, v[i]};
			r = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/i2cm_step.sv */
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the bus sequencer: next engine state and the tick's result.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::eng_st_t  st,
	input  logic [2:0]         func,
	input  logic [7:0]         tx_byte,
	input  logic               give_ack,
	input  logic               sda_level,
	input  logic               scl_level,
	input  logic [15:0]        half_period,
	output i2cm_pkg::eng_st_t  st_nxt,
	output i2cm_pkg::eng_res_t res
);

	logic       go;
	logic       done;
	logic [5:0] p;
	logic [1:0] k;

	always_comb begin
		st_nxt = st;
		go     = 1'b0;
		done   = 1'b0;

		// wait / stretch / launch
		if (st.cmd == i2cm_pkg::CMD_NONE) begin
			if (func inside {i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP,
					i2cm_pkg::CMD_SEND, i2cm_pkg::CMD_RECV}) begin
				st_nxt.cmd      = i2cm_pkg::cmd_t'(func);
				st_nxt.phase    = '0;
				st_nxt.wait_cnt = '0;
				st_nxt.stretch  = 1'b0;
				st_nxt.shift    = (func == i2cm_pkg::CMD_SEND) ? tx_byte : 8'd0;
				if (func == i2cm_pkg::CMD_RECV) begin
					st_nxt.ack_give = give_ack;
				end
				go = 1'b1;
			end
		end else if (st.wait_cnt != 16'd0) begin
			st_nxt.wait_cnt = st.wait_cnt - 16'd1;
		end else if (st.stretch) begin
			if (scl_level) begin
				st_nxt.stretch = 1'b0;
				go             = 1'b1;
			end
		end else begin
			go = 1'b1;
		end

		p = st_nxt.phase;
		k = i2cm_pkg::mod3(p[4:0]);

		if (go) begin
			st_nxt.phase = p + 6'd1;
			case (st_nxt.cmd)
				i2cm_pkg::CMD_START: begin
					case (p)
						6'd0: begin st_nxt.sda_drv = 1'b0; st_nxt.wait_cnt = half_period; end
						6'd1: begin
							st_nxt.scl_drv = 1'b0; st_nxt.stretch = 1'b1;
							st_nxt.wait_cnt = half_period;
						end
						6'd2: begin st_nxt.sda_drv = 1'b1; st_nxt.wait_cnt = half_period; end
						6'd3: begin
							st_nxt.scl_drv = 1'b1; st_nxt.stretch = 1'b0;
							st_nxt.wait_cnt = half_period;
						end
						default: done = 1'b1;
					endcase
				end
				i2cm_pkg::CMD_STOP: begin
					case (p)
						6'd0: begin st_nxt.sda_drv = 1'b1; st_nxt.wait_cnt = half_period; end
						6'd1: begin
							st_nxt.scl_drv = 1'b0; st_nxt.stretch = 1'b1;
							st_nxt.wait_cnt = half_period;
						end
						6'd2: begin st_nxt.sda_drv = 1'b0; st_nxt.wait_cnt = half_period; end
						default: done = 1'b1;
					endcase
				end
				i2cm_pkg::CMD_SEND: begin
					st_nxt.wait_cnt = half_period;
					if (p < i2cm_pkg::SEND_BIT_END) begin
						if (k == 2'd0) begin
							st_nxt.sda_drv = ~st_nxt.shift[7];
						end else if (k == 2'd1) begin
							st_nxt.scl_drv = 1'b0;
							st_nxt.stretch = 1'b1;
						end else begin
							st_nxt.shift   = {st_nxt.shift[6:0], 1'b0};
							st_nxt.scl_drv = 1'b1;
							st_nxt.stretch = 1'b0;
						end
					end else if (p == i2cm_pkg::SEND_ACK_SDA) begin
						st_nxt.sda_drv = 1'b0;
					end else if (p == i2cm_pkg::SEND_ACK_UP) begin
						st_nxt.scl_drv = 1'b0;
						st_nxt.stretch = 1'b1;
					end else if (p == i2cm_pkg::SEND_ACK_DN) begin
						st_nxt.ack     = ~sda_level;
						st_nxt.scl_drv = 1'b1;
						st_nxt.stretch = 1'b0;
					end else begin
						st_nxt.wait_cnt = st.wait_cnt;
						done            = 1'b1;
					end
				end
				i2cm_pkg::CMD_RECV: begin
					st_nxt.wait_cnt = half_period;
					if (p < i2cm_pkg::RECV_BIT_END) begin
						if (!p[0]) begin
							st_nxt.scl_drv = 1'b0;
							st_nxt.stretch = 1'b1;
						end else begin
							st_nxt.shift   = {st_nxt.shift[6:0], sda_level};
							st_nxt.scl_drv = 1'b1;
							st_nxt.stretch = 1'b0;
						end
					end else if (p == i2cm_pkg::RECV_ACK_SDA) begin
						st_nxt.sda_drv = st_nxt.ack_give;
					end else if (p == i2cm_pkg::RECV_ACK_UP) begin
						st_nxt.scl_drv = 1'b0;
						st_nxt.stretch = 1'b1;
					end else if (p == i2cm_pkg::RECV_ACK_DN) begin
						st_nxt.scl_drv = 1'b1;
						st_nxt.stretch = 1'b0;
					end else if (p == i2cm_pkg::RECV_REL_SDA) begin
						st_nxt.sda_drv = 1'b0;
					end else begin
						st_nxt.wait_cnt = st.wait_cnt;
						st_nxt.rx_hold  = st_nxt.shift;
						done            = 1'b1;
					end
				end
				default: done = 1'b1;
			endcase

			if (done) begin
				st_nxt.cmd   = i2cm_pkg::CMD_NONE;
				st_nxt.phase = '0;
			end
		end

		res.sda_pull_low = st_nxt.sda_drv;
		res.scl_pull_low = st_nxt.scl_drv;
		res.busy_res     = (st_nxt.cmd != i2cm_pkg::CMD_NONE);
		res.done_res     = done;
		res.rx_byte      = st_nxt.rx_hold;
		res.ack_seen     = st_nxt.ack;
	end

endmodule

/* rtl/core/i2c_master_byte_engine_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Open-drain I2C master sequencer advanced by one stream request per tick.
// ----------------------------------------------------------------------------
// Each accepted request is one tick of the bus sequencer and yields exactly
// one result request. The core sustains one request per clock while the
// result stream is not stalled: a request is captured in the _s1 input
// register, then the tick logic (i2cm_step) writes the engine state and the
// result register together as _s1 moves on. Backpressure
// on m_tready holds the result register, and the input register then holds
// its request; s_tready stays high whenever the _s1 stage is empty or moves.
// A command (start, stop, send, receive) is taken only while idle; after
// every SDA/SCL change the engine counts half_period_ticks ticks, and after
// releasing SCL it also waits until scl_level reads high (clock stretching).
// half_period_ticks resets to 5 and is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while no request is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_macros.svh"

module i2c_master_byte_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: half_period_ticks
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // tx_byte[7:0], give_ack[8], sda_level[9], scl_level[10]
	input  logic [2:0]  s_tuser,  // func[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// sda_pull_low[0], scl_pull_low[1], busy_res[2], done_res[3], rx_byte[11:4], ack_seen[12]
	output logic [15:0] m_tdata
);

	logic [15:0]        half_period_q;
	i2cm_pkg::eng_st_t  st_q;
	i2cm_pkg::eng_st_t  st_nxt;
	i2cm_pkg::eng_res_t res;

	logic       valid_s1;
	logic [2:0] func_s1;
	logic [7:0] tx_s1;
	logic       gack_s1;
	logic       sda_s1;
	logic       scl_s1;
	logic       adv;

	// _s1 moves into the result register when that register is free or drains
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	i2cm_step u_step (
		.st          (st_q),
		.func        (func_s1),
		.tx_byte     (tx_s1),
		.give_ack    (gack_s1),
		.sda_level   (sda_s1),
		.scl_level   (scl_s1),
		.half_period (half_period_q),
		.st_nxt      (st_nxt),
		.res         (res)
	);

	// control: valids, engine state, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			m_tvalid      <= 1'b0;
			half_period_q <= i2cm_pkg::HALF_PERIOD_RST;
			st_q          <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
				st_q     <= st_nxt;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_wr_en) begin
				half_period_q <= cfg_wr_data;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			tx_s1   <= s_tdata[7:0];
			gack_s1 <= s_tdata[8];
			sda_s1  <= s_tdata[9];
			scl_s1  <= s_tdata[10];
		end
		if (adv) begin
			m_tdata <= {3'b000, res.ack_seen, res.rx_byte, res.done_res,
				res.busy_res, res.scl_pull_low, res.sda_pull_low};
		end
	end

	// a completing tick always reports idle
	`I2CM_ASSERT_IMPL(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2])
	// idle engine carries no pending countdown or stretch wait
	`I2CM_ASSERT_IMPL(a_idle_clean, st_q.cmd == i2cm_pkg::CMD_NONE,
		st_q.wait_cnt == 16'd0 && !st_q.stretch)
	// a stalled input stage keeps its request
	`I2CM_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(func_s1))

endmodule

/* test/i2c_tick_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_tick_checker
// Follows the request and result streams of the byte engine, predicts the
// result of every accepted request and compares them field by field.
// ----------------------------------------------------------------------------
module i2c_tick_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // tx_byte[7:0], give_ack[8], sda_level[9], scl_level[10]
	input  logic [2:0]  s_tuser,  // func[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	// sda_pull_low[0], scl_pull_low[1], busy_res[2], done_res[3], rx_byte[11:4], ack_seen[12]
	input  logic [15:0] m_tdata,
	output int          fail_count,
	output int          pending,
	output logic        eng_busy
);

	// step numbers inside the send and receive sequences
	localparam logic [5:0] SND_DATA_END = 6'd24;
	localparam logic [5:0] SND_ACK_REL  = 6'd24;
	localparam logic [5:0] SND_ACK_UP   = 6'd25;
	localparam logic [5:0] SND_ACK_DN   = 6'd26;
	localparam logic [5:0] RCV_DATA_END = 6'd16;
	localparam logic [5:0] RCV_ACK_DRV  = 6'd16;
	localparam logic [5:0] RCV_ACK_UP   = 6'd17;
	localparam logic [5:0] RCV_ACK_DN   = 6'd18;
	localparam logic [5:0] RCV_SDA_REL  = 6'd19;

	// MSB first, so ack lands on bit 12 and sda on bit 0
	typedef struct packed {
		logic       ack;
		logic [7:0] rx;
		logic       done;
		logic       busy;
		logic       scl_low;
		logic       sda_low;
	} line_res_t;

	logic [15:0]     half_ticks;
	i2cm_pkg::cmd_t  act_cmd;
	logic [5:0]      step_no;
	logic [15:0]     count_down;
	logic            hold_for_scl;
	logic [7:0]      shifter;
	logic            sda_drv_q;
	logic            scl_drv_q;
	logic            ack_latched;
	logic            ack_to_drive;
	logic [7:0]      rx_last;
	line_res_t       expected_lines[$];

	assign eng_busy = (act_cmd != i2cm_pkg::CMD_NONE);

	function automatic void drive_sda(input logic high);
		sda_drv_q = ~high;
		count_down = half_ticks;
	endfunction

	// releasing SCL also waits for the line to read high
	function automatic void drive_scl(input logic high);
		scl_drv_q = ~high;
		count_down = half_ticks;
		hold_for_scl = high;
	endfunction

	// one line change of the active command; 1 once the command is over
	function automatic logic bus_step(input logic sda_in);
		logic [5:0] p;
		logic       fin;
		p = step_no;
		fin = 1'b0;
		step_no = step_no + 6'd1;
		case (act_cmd)
			i2cm_pkg::CMD_START: begin
				case (p)
					6'd0: drive_sda(1'b1);
					6'd1: drive_scl(1'b1);
					6'd2: drive_sda(1'b0);
					6'd3: drive_scl(1'b0);
					default: fin = 1'b1;
				endcase
			end
			i2cm_pkg::CMD_STOP: begin
				case (p)
					6'd0: drive_sda(1'b0);
					6'd1: drive_scl(1'b1);
					6'd2: drive_sda(1'b1);
					default: fin = 1'b1;
				endcase
			end
			i2cm_pkg::CMD_SEND: begin
				if (p < SND_DATA_END) begin
					case (p % 3)
						0: drive_sda(shifter[7]);
						1: drive_scl(1'b1);
						default: begin
							shifter = {shifter[6:0], 1'b0};
							drive_scl(1'b0);
						end
					endcase
				end else if (p == SND_ACK_REL) begin
					drive_sda(1'b1);
				end else if (p == SND_ACK_UP) begin
					drive_scl(1'b1);
				end else if (p == SND_ACK_DN) begin
					ack_latched = ~sda_in;
					drive_scl(1'b0);
				end else begin
					fin = 1'b1;
				end
			end
			i2cm_pkg::CMD_RECV: begin
				if (p < RCV_DATA_END) begin
					if (!p[0]) begin
						drive_scl(1'b1);
					end else begin
						shifter = {shifter[6:0], sda_in};
						drive_scl(1'b0);
					end
				end else if (p == RCV_ACK_DRV) begin
					drive_sda(~ack_to_drive);
				end else if (p == RCV_ACK_UP) begin
					drive_scl(1'b1);
				end else if (p == RCV_ACK_DN) begin
					drive_scl(1'b0);
				end else if (p == RCV_SDA_REL) begin
					drive_sda(1'b1);
				end else begin
					rx_last = shifter;
					fin = 1'b1;
				end
			end
			default: fin = 1'b1;
		endcase
		return fin;
	endfunction

	// one bus tick: take a command when idle, else count down or wait for SCL
	function automatic line_res_t advance_tick(input logic [2:0] func, input logic [15:0] d);
		logic      go;
		logic      fin;
		line_res_t r;
		go = 1'b0;
		fin = 1'b0;
		if (act_cmd == i2cm_pkg::CMD_NONE) begin
			if (func >= i2cm_pkg::CMD_START && func <= i2cm_pkg::CMD_RECV) begin
				act_cmd = i2cm_pkg::cmd_t'(func);
				step_no = 6'd0;
				count_down = 16'd0;
				hold_for_scl = 1'b0;
				shifter = (func == i2cm_pkg::CMD_SEND) ? d[7:0] : 8'h00;
				if (func == i2cm_pkg::CMD_RECV)
					ack_to_drive = d[8];
				go = 1'b1;
			end
		end else if (count_down != 16'd0) begin
			count_down = count_down - 16'd1;
		end else if (hold_for_scl) begin
			if (d[10]) begin
				hold_for_scl = 1'b0;
				go = 1'b1;
			end
		end else begin
			go = 1'b1;
		end
		if (go)
			fin = bus_step(d[9]);
		if (fin) begin
			act_cmd = i2cm_pkg::CMD_NONE;
			step_no = 6'd0;
		end
		r.sda_low = sda_drv_q;
		r.scl_low = scl_drv_q;
		r.busy    = (act_cmd != i2cm_pkg::CMD_NONE);
		r.done    = fin;
		r.rx      = rx_last;
		r.ack     = ack_latched;
		return r;
	endfunction

	task automatic show(input string field, input int want, input int got);
		$display("%0t: %s mismatch, expected 0x%02h actual 0x%02h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_res_t want;
		line_res_t got;
		if (!arst_n) begin
			half_ticks = i2cm_pkg::HALF_PERIOD_RST;
			act_cmd = i2cm_pkg::CMD_NONE;
			step_no = 6'd0;
			count_down = 16'd0;
			hold_for_scl = 1'b0;
			shifter = 8'h00;
			sda_drv_q = 1'b0;
			scl_drv_q = 1'b0;
			ack_latched = 1'b0;
			ack_to_drive = 1'b0;
			rx_last = 8'h00;
			expected_lines.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[12:0];
				if (expected_lines.size() == 0) begin
					$display("%0t: result 0x%04h with no request pending", $time, m_tdata);
					fail_count++;
				end else begin
					want = expected_lines.pop_front();
					if (got != want) begin
						if (got.sda_low != want.sda_low)
							show("sda_pull_low", want.sda_low, got.sda_low);
						if (got.scl_low != want.scl_low)
							show("scl_pull_low", want.scl_low, got.scl_low);
						if (got.busy != want.busy)
							show("busy_res", want.busy, got.busy);
						if (got.done != want.done)
							show("done_res", want.done, got.done);
						if (got.rx != want.rx)
							show("rx_byte", want.rx, got.rx);
						if (got.ack != want.ack)
							show("ack_seen", want.ack, got.ack);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				half_ticks = cfg_wr_data;
			if (s_tvalid && s_tready)
				expected_lines.push_back(advance_tick(s_tuser, s_tdata));
		end
		pending = expected_lines.size();
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus ticks into the I2C master byte engine: directed commands first,
// then random start/byte/stop transactions at several half periods, ending
// with one stop at a long half period. A side checker predicts and
// compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;

	// how a run of ticks samples SDA
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	// receiver stall patterns
	localparam int RDY_FULL   = 0;
	localparam int RDY_MOSTLY = 1;
	localparam int RDY_RARELY = 2;
	localparam int RDY_EVERY3 = 3;

	// func codes outside the command set, ignored like no command
	localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
	localparam logic [2:0] FUNC_RSVD_MID   = 3'd6;
	localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;  // tx_byte[7:0], give_ack[8], sda_level[9], scl_level[10]
	logic [2:0]  s_tuser = 3'd0;   // func[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// sda_pull_low[0], scl_pull_low[1], busy_res[2], done_res[3], rx_byte[11:4], ack_seen[12]
	logic [15:0] m_tdata;

	int   fail_count;
	int   pending;
	logic eng_busy;

	int burst_left = 0;
	int items_sent = 0;
	int rdy_mode = RDY_FULL;
	int rdy_left = 0;
	int rdy_tick = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_master_byte_engine_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	i2c_tick_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.eng_busy    (eng_busy)
	);

	// receiver: switches between stall patterns after runs of random length
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(RDY_FULL, RDY_EVERY3);
			rdy_left = $urandom_range(16, 256);
		end else begin
			rdy_left--;
		end
		rdy_tick++;
		case (rdy_mode)
			RDY_FULL:   m_tready <= 1'b1;
			RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
			RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
			default:    m_tready <= (rdy_tick % 3 == 0);
		endcase
	end

	function automatic logic pick_sda(input int mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// SCL reads high in pct percent of ticks; the rest stretch the clock
	function automatic logic pick_scl(input int pct);
		return ($urandom_range(1, 100) <= pct);
	endfunction

	// Entered just after a falling edge; returns just after the falling edge
	// that follows acceptance, with tvalid still high. Bursts of random
	// length are separated by random gaps.
	task automatic put_item(input logic [2:0] func, input logic [7:0] tx, input logic gack,
			input logic sda, input logic scl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {5'd0, scl, sda, gack, tx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Start a command on an idle engine, then keep ticking until it is idle
	// again. Filler ticks carry random funcs, so commands while busy (and on
	// the completing tick) are exercised as well.
	task automatic run_cmd(input i2cm_pkg::cmd_t cmd, input logic [7:0] tx, input logic gack,
			input int sda_mode, input int scl_pct);
		put_item(cmd, tx, gack, pick_sda(sda_mode), pick_scl(scl_pct));
		while (eng_busy)
			put_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
				pick_sda(sda_mode), pick_scl(scl_pct));
	endtask

	// stop sending and let every expected result arrive
	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic set_half(input logic [15:0] v);
		drain(4);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly well-formed transactions (start, one to three bytes, stop) with
	// random data, acks and stretching; the rest is stray commands out of
	// order, reserved func codes and empty ticks.
	task automatic random_traffic(input int ticks);
		int stop_at;
		int n;
		stop_at = items_sent + ticks;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, 80);
				n = $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(0, 1))
						run_cmd(i2cm_pkg::CMD_SEND, 8'($urandom), 1'($urandom),
							SDA_RAND, 80);
					else
						run_cmd(i2cm_pkg::CMD_RECV, 8'($urandom), 1'($urandom),
							SDA_RAND, 80);
				end
				run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 80);
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: run_cmd(i2cm_pkg::cmd_t'($urandom_range(i2cm_pkg::CMD_START,
							i2cm_pkg::CMD_RECV)), 8'($urandom), 1'($urandom), SDA_RAND, 70);
						1: put_item(3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST)),
							8'($urandom), 1'($urandom), pick_sda(SDA_RAND), pick_scl(50));
						default: put_item(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom),
							pick_sda(SDA_RAND), pick_scl(50));
					endcase
				end
			end
			// now and then hold off until the pipeline is empty
			if ($urandom_range(0, 11) == 0)
				drain(1);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset half period: reserved codes and an empty tick leave it idle
		put_item(FUNC_RSVD_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1);
		put_item(FUNC_RSVD_MID, 8'h00, 1'b0, 1'b0, 1'b0);
		put_item(FUNC_RSVD_LAST, 8'hFF, 1'b1, 1'b0, 1'b1);
		put_item(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b1, 1'b1);
		run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND, 100);

		// half period of 1: every command, byte and ack extremes
		set_half(16'd1);
		run_cmd(i2cm_pkg::CMD_SEND, 8'h00, 1'b0, SDA_LOW, 100);   // slave acks
		run_cmd(i2cm_pkg::CMD_SEND, 8'hFF, 1'b1, SDA_HIGH, 100);  // slave nacks
		run_cmd(i2cm_pkg::CMD_RECV, 8'hFF, 1'b1, SDA_HIGH, 100);  // all ones, master acks
		run_cmd(i2cm_pkg::CMD_RECV, 8'h00, 1'b0, SDA_LOW, 100);   // all zeros, master nacks
		run_cmd(i2cm_pkg::CMD_SEND, 8'hA5, 1'b0, SDA_RAND, 40);   // heavy clock stretching
		run_cmd(i2cm_pkg::CMD_RECV, 8'h5A, 1'b1, SDA_RAND, 40);
		run_cmd(i2cm_pkg::CMD_STOP, 8'hFF, 1'b1, SDA_RAND, 25);
		run_cmd(i2cm_pkg::CMD_START, 8'h3C, 1'b0, SDA_RAND, 100);
		run_cmd(i2cm_pkg::CMD_STOP, 8'hC3, 1'b1, SDA_RAND, 100);
		run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND, 100);  // stop with no start before it

		set_half(16'd1);
		random_traffic(130);
		set_half(16'd2);
		random_traffic(110);
		set_half(16'($urandom_range(1, 4)));
		random_traffic(100);

		// long half period: one full stop condition
		set_half(16'd60);
		run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 90);

		drain(8);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
